// File: hw/rtl/lss_pkg.sv
// Shared types, codes and constants of the line substring search block.
// No dependencies; every RTL file of the block refers to it by scoped names.
package lss_pkg;

  // Defaults of the top-level parameters.
  localparam int NEEDLE_MAX_DEF  = 32;
  localparam int COLUMN_BITS_DEF = 16;

  // The needle registers hold at most this many bytes.
  localparam int NEEDLE_BYTES = 32;
  localparam int NEEDLE_WORDS = 4;
  // Width of a needle length value (holds 0 to 32 and beyond, up to 63).
  localparam int LEN_BITS     = 6;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_LOW    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_SECOND = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_THIRD  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_HIGH   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_LENGTH = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CASE_SENSITIVE = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_RESULTS   = 3'd6;

  // Input word modes.
  localparam logic [1:0] MODE_BYTE       = 2'd0;
  localparam logic [1:0] MODE_END_DOC    = 2'd1;
  localparam logic [1:0] MODE_END_SEARCH = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_TRUNC = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Characters.
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  // Control shared by every cell of the window row.
  typedef struct packed {
    logic shift;
    logic clear;
    logic caseless;
  } cell_ctrl_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] doc;
    logic [31:0] line;
    logic [15:0] column;
    logic [15:0] count;
  } result_t;

  // Fold an ASCII capital to lower case when caseless compare is on.
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic caseless);
    logic [7:0] r;
    r = b;
    if (caseless && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      r = b - CHAR_UPPER_A + CHAR_LOWER_A;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/lss_cell.sv
// One window cell: holds one document byte and its valid mark, compares the
// byte it is about to take against its needle byte. Depends on lss_pkg.
module lss_cell (
  input  logic                clk,
  input  logic                rst,
  input  lss_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          prev_byte,
  input  logic                prev_valid,
  input  logic [7:0]          needle_byte,
  input  logic                in_use,
  output logic [7:0]          cur_byte,
  output logic                cur_valid,
  output logic                match
);

  // The compare looks at the incoming byte, which is this cell's value after
  // the shift that the current word causes.
  assign match = !in_use ||
                 (prev_valid && (lss_pkg::fold_byte(prev_byte, ctrl.caseless) == needle_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (ctrl.clear) begin
      cur_valid <= 1'b0;
    end else if (ctrl.shift) begin
      cur_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      cur_byte <= prev_byte;
    end
  end

endmodule

// File: hw/rtl/lss_out_queue.sv
// Two-entry result queue between the search logic and the output stream.
// Depends on lss_pkg for the result word type.
module lss_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lss_pkg::result_t din,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output lss_pkg::result_t dout
);

  lss_pkg::result_t q0;
  lss_pkg::result_t q1;
  logic [1:0]       count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign dout      = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        q0 <= din;
      end else begin
        q0 <= q1;
        q1 <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        q0 <= din;
      end else begin
        q1 <= din;
      end
    end else if (pop) begin
      q0 <= q1;
    end
  end

endmodule

// File: hw/rtl/line_substring_search_top.sv
// Top level of the line substring search block: configuration registers,
// line and hit bookkeeping, the row of window cells and the result queue.
// Depends on lss_pkg, lss_cell and lss_out_queue.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  s_*     | in        | s_tvalid / s_tready | tuser: mode; tdata: text_byte, doc
//  m_*     | out       | m_tvalid / m_tready | tuser: kind; tdata: doc, line, col, count
//  cfg_*   | in        | cfg_we              | cfg_index, cfg_data
//
// One input word is taken per clock. The byte enters the cell row, and every
// cell compares its next value with its needle byte in the same cycle, so
// the match decision and the line bookkeeping are done in that cycle.
// A result enters a two-entry output queue at the edge that accepts its word
// and shows on the master side from the next cycle if the queue was empty.
// s_tready drops only while both queue entries hold untaken results. Reset
// is synchronous on rst; it restores the register reset values and empties
// the window, the line state and the queue. There is no clearing pass.
module line_substring_search_top #(
  parameter int NEEDLE_MAX  = lss_pkg::NEEDLE_MAX_DEF,
  parameter int COLUMN_BITS = lss_pkg::COLUMN_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [23:0]                        s_tdata,  // text_byte[7:0], doc_index[23:8]
  input  logic [1:0]                         s_tuser,  // mode[1:0]
  // Result stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [79:0]                        m_tdata,  // hit_doc[15:0], hit_line[47:16],
                                                       // hit_column[63:48], hit_count[79:64]
  output logic [1:0]                         m_tuser,  // kind[1:0]
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [lss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int LB = lss_pkg::LEN_BITS;
  // Longest usable needle: the cell row and the needle registers both bound it.
  localparam int CAP = (NEEDLE_MAX < lss_pkg::NEEDLE_BYTES) ? NEEDLE_MAX
                                                            : lss_pkg::NEEDLE_BYTES;
  localparam logic [LB-1:0]          CAP_LEN = LB'(CAP);
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
  localparam logic [31:0]            LINE_MAX = '1;

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [63:0]   needle_word [lss_pkg::NEEDLE_WORDS];
  logic [LB-1:0] needle_length;
  logic          case_sensitive;
  logic [15:0]   max_results;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < lss_pkg::NEEDLE_WORDS; w++) begin
        needle_word[w] <= '0;
      end
      needle_length  <= LB'(1);
      case_sensitive <= 1'b1;
      max_results    <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        lss_pkg::REG_NEEDLE_LOW:     needle_word[0] <= cfg_data;
        lss_pkg::REG_NEEDLE_SECOND:  needle_word[1] <= cfg_data;
        lss_pkg::REG_NEEDLE_THIRD:   needle_word[2] <= cfg_data;
        lss_pkg::REG_NEEDLE_HIGH:    needle_word[3] <= cfg_data;
        lss_pkg::REG_NEEDLE_LENGTH:  needle_length  <= cfg_data[LB-1:0];
        lss_pkg::REG_CASE_SENSITIVE: case_sensitive <= cfg_data[0];
        lss_pkg::REG_MAX_RESULTS:    max_results    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Needle length in effect: zero acts as one, and it never exceeds the row.
  logic [LB-1:0] len;
  always_comb begin
    len = needle_length;
    if (needle_length == '0) begin
      len = LB'(1);
    end else if (needle_length > CAP_LEN) begin
      len = CAP_LEN;
    end
  end

  // Needle as a byte array, byte 0 from the low bits of the first word.
  logic [7:0] needle_b [lss_pkg::NEEDLE_BYTES];
  for (genvar k = 0; k < lss_pkg::NEEDLE_BYTES; k++) begin : g_needle
    assign needle_b[k] = needle_word[k / 8][(k % 8) * 8 +: 8];
  end

  // ---------------------------------------------------------------------
  // Input word decode.
  // ---------------------------------------------------------------------
  logic [1:0]  mode;
  logic [7:0]  text_byte;
  logic [15:0] doc_index;
  logic        acc;

  assign mode      = s_tuser;
  assign text_byte = s_tdata[7:0];
  assign doc_index = s_tdata[23:8];
  assign acc       = s_tvalid && s_tready;

  // ---------------------------------------------------------------------
  // Search state.
  // ---------------------------------------------------------------------
  logic [LB-1:0]          overlap_guard;
  logic [31:0]            line_number;
  logic [COLUMN_BITS-1:0] column;
  logic [15:0]            hits_so_far;
  logic                   stopped;
  logic                   pending_cr_hit;
  logic [COLUMN_BITS-1:0] pending_column;
  logic [15:0]            pending_doc;

  logic is_content;
  logic is_lf;
  logic is_cr;
  logic end_doc;
  logic end_search;
  logic pend_fire;
  logic full_hits;
  logic stop_on_pending;
  logic proceed;
  logic hit;
  logic report;

  assign end_doc    = acc && (mode == lss_pkg::MODE_END_DOC);
  assign end_search = acc && (mode == lss_pkg::MODE_END_SEARCH);
  // Content bytes count only while the search has not stopped.
  assign is_content = acc && (mode == lss_pkg::MODE_BYTE) && !stopped;
  assign is_lf      = (text_byte == lss_pkg::CHAR_LF);
  assign is_cr      = (text_byte == lss_pkg::CHAR_CR);
  assign full_hits  = (hits_so_far >= max_results);

  // A match held on a CR is released by any byte other than LF. If that
  // report hits the limit, the byte itself is not looked at.
  assign pend_fire       = is_content && !is_lf && pending_cr_hit;
  assign stop_on_pending = pend_fire && full_hits;
  assign proceed         = is_content && !is_lf && !stop_on_pending;

  // ---------------------------------------------------------------------
  // Cell row: cell 0 takes the new byte, cell i holds the byte i places back.
  // ---------------------------------------------------------------------
  lss_pkg::cell_ctrl_t ctrl;
  logic [7:0]          cell_byte  [NEEDLE_MAX];
  logic                cell_valid [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] cell_match;

  assign ctrl.shift    = proceed;
  assign ctrl.clear    = end_doc || end_search || (is_content && is_lf);
  assign ctrl.caseless = !case_sensitive;

  for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_cell
    logic [7:0] prev_byte;
    logic       prev_valid;
    logic [7:0] nb;
    logic       in_use;

    if (i == 0) begin : g_head
      assign prev_byte  = text_byte;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_byte  = cell_byte[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    // Cell i lines up with needle byte len-1-i.
    if (i < CAP) begin : g_used
      logic [LB-1:0] pos;
      assign pos    = len - LB'(i) - LB'(1);
      assign in_use = (LB'(i) < len);
      assign nb     = lss_pkg::fold_byte(needle_b[pos[4:0]], !case_sensitive);
    end else begin : g_spare
      assign in_use = 1'b0;
      assign nb     = '0;
    end

    lss_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_byte  (prev_byte),
      .prev_valid (prev_valid),
      .needle_byte(nb),
      .in_use     (in_use),
      .cur_byte   (cell_byte[i]),
      .cur_valid  (cell_valid[i]),
      .match      (cell_match[i])
    );
  end

  // The valid marks form a prefix, so every used cell matching also means
  // the window holds at least len bytes.
  assign hit = proceed && (overlap_guard == '0) && (&cell_match);

  // Column after this byte, and the start column of a match ending here.
  logic [COLUMN_BITS-1:0] col_new;
  logic [COLUMN_BITS-1:0] len_col;
  logic [COLUMN_BITS-1:0] start_col;

  assign col_new = (column < COL_MAX) ? column + COLUMN_BITS'(1) : column;
  assign len_col = COLUMN_BITS'(len);
  assign start_col = (col_new >= COL_MAX || col_new < len_col) ? COL_MAX
                                                               : col_new - len_col + COLUMN_BITS'(1);

  // One report per word at most: the released CR match has priority, and a
  // new match ending on a CR is held instead of reported.
  logic                   report_b;
  logic [15:0]            rep_doc;
  logic [COLUMN_BITS-1:0] rep_col;
  logic [COLUMN_BITS+15:0] rep_col_ext;

  assign report_b    = hit && !is_cr && !pend_fire;
  assign report      = pend_fire || report_b;
  assign rep_doc     = pend_fire ? pending_doc : doc_index;
  assign rep_col     = pend_fire ? pending_column : start_col;
  assign rep_col_ext = {16'b0, rep_col};

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_guard  <= '0;
      line_number    <= 32'd1;
      column         <= '0;
      hits_so_far    <= '0;
      stopped        <= 1'b0;
      pending_cr_hit <= 1'b0;
    end else begin
      if (end_doc || end_search) begin
        overlap_guard  <= '0;
        line_number    <= 32'd1;
        column         <= '0;
        pending_cr_hit <= 1'b0;
      end else if (is_content && is_lf) begin
        overlap_guard  <= '0;
        column         <= '0;
        pending_cr_hit <= 1'b0;
        if (line_number < LINE_MAX) begin
          line_number <= line_number + 32'd1;
        end
      end else begin
        // A released match clears the hold unless this byte holds a new one.
        if (pend_fire || (hit && is_cr)) begin
          pending_cr_hit <= hit && is_cr;
        end
        if (proceed) begin
          column <= col_new;
          if (overlap_guard != '0) begin
            overlap_guard <= overlap_guard - LB'(1);
          end else if (hit) begin
            overlap_guard <= len - LB'(1);
          end
        end
      end

      if (end_search) begin
        hits_so_far <= '0;
        stopped     <= 1'b0;
      end else if (report) begin
        if (full_hits) begin
          stopped <= 1'b1;
        end else begin
          hits_so_far <= hits_so_far + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && is_cr) begin
      pending_column <= start_col;
      pending_doc    <= doc_index;
    end
  end

  // ---------------------------------------------------------------------
  // Result assembly and output queue.
  // ---------------------------------------------------------------------
  lss_pkg::result_t res;
  lss_pkg::result_t q_out;
  logic             push;
  logic             q_full;

  assign push = report || end_search;

  always_comb begin
    if (end_search) begin
      res.kind   = lss_pkg::KIND_DONE;
      res.doc    = '0;
      res.line   = '0;
      res.column = '0;
      res.count  = hits_so_far;
    end else begin
      res.kind   = full_hits ? lss_pkg::KIND_TRUNC : lss_pkg::KIND_HIT;
      res.doc    = rep_doc;
      res.line   = line_number;
      res.column = rep_col_ext[15:0];
      res.count  = full_hits ? hits_so_far : hits_so_far + 16'd1;
    end
  end

  lss_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (res),
    .full     (q_full),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .dout     (q_out)
  );

  assign s_tready = !q_full;
  assign m_tdata  = {q_out.count, q_out.column, q_out.line, q_out.doc};
  assign m_tuser  = q_out.kind;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // Once stopped, no further hit may be reported.
  a_no_hit_when_stopped: assert property (@(posedge clk) disable iff (rst)
    (push && res.kind == lss_pkg::KIND_HIT) |-> !stopped)
    else $error("hit reported after the search stopped");

  // A truncated result stops the search.
  a_trunc_stops: assert property (@(posedge clk) disable iff (rst)
    (push && res.kind == lss_pkg::KIND_TRUNC) |=> stopped)
    else $error("truncated result did not stop the search");

  // The done result returns the hit state to its reset values.
  a_done_resets: assert property (@(posedge clk) disable iff (rst)
    (push && res.kind == lss_pkg::KIND_DONE) |=> (hits_so_far == '0 && !stopped))
    else $error("done result left hit state behind");

  // A held match always sits on a CR at the head of the window.
  a_pending_on_cr: assert property (@(posedge clk) disable iff (rst)
    pending_cr_hit |-> (cell_valid[0] && cell_byte[0] == lss_pkg::CHAR_CR))
    else $error("held match without a CR at the window head");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for line_substring_search_top: a behavioral search
// model predicts every result word, and a checker compares what the block sends.
// Depends on lss_pkg and the RTL of line_substring_search_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The input mode that the block must ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Largest column value with the default COLUMN_BITS of 16.
  localparam int unsigned COL_SAT = 32'h0000_FFFF;
  localparam int unsigned LINE_SAT = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // text_byte[7:0], doc_index[23:8]
  logic [1:0]  s_tuser = '0;    // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;         // hit_doc[15:0], hit_line[47:16], hit_column[63:48],
                                // hit_count[79:64]
  logic [1:0]  m_tuser;         // kind[1:0]
  logic                               cfg_we = 1'b0;
  logic [lss_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [lss_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  line_substring_search_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Search model. It keeps its own copy of the registers and of the line and
  // hit state, and is stepped once for every word the block accepts.
  // ---------------------------------------------------------------------------
  logic [255:0] cfg_needle;
  logic [5:0]   cfg_len;
  logic         cfg_exact;
  logic [15:0]  cfg_limit;

  logic [7:0]  recent_bytes [32];   // recent_bytes[0] is the newest byte
  int unsigned recent_fill;
  int unsigned skip_count;          // bytes still covered by the previous match
  int unsigned line_no;
  int unsigned col_no;
  int unsigned match_total;
  bit          halted;
  bit          cr_match_held;
  int unsigned held_col;
  logic [15:0] held_doc;

  lss_pkg::result_t awaited_results [$];

  int words_sent;
  int mismatches;
  int hits_seen;
  int truncs_seen;
  int dones_seen;

  // Idle percentages for the sender and the receiver, changed by some tests.
  int sender_idle_pct = 0;
  int sink_idle_pct = 0;
  int sink_stall_left = 0;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (!cfg_exact && c >= lss_pkg::CHAR_UPPER_A && c <= lss_pkg::CHAR_UPPER_Z) begin
      return c + (lss_pkg::CHAR_LOWER_A - lss_pkg::CHAR_UPPER_A);
    end
    return c;
  endfunction

  function automatic int unsigned needle_span();
    if (cfg_len == 0) return 1;
    if (cfg_len > 32) return 32;
    return 32'(cfg_len);
  endfunction

  function automatic void clear_line();
    foreach (recent_bytes[i]) recent_bytes[i] = '0;
    recent_fill = 0;
    skip_count = 0;
    line_no = 1;
    col_no = 0;
    cr_match_held = 1'b0;
    held_col = 0;
    held_doc = '0;
  endfunction

  function automatic void clear_search();
    clear_line();
    match_total = 0;
    halted = 1'b0;
  endfunction

  // A match becomes a hit, or the truncated stop once the limit is reached.
  function automatic void tally_match(output lss_pkg::result_t r, input logic [15:0] doc,
                                      input int unsigned col);
    if (match_total >= cfg_limit) begin
      halted = 1'b1;
      r.kind = lss_pkg::KIND_TRUNC;
    end else begin
      match_total++;
      r.kind = lss_pkg::KIND_HIT;
    end
    r.doc = doc;
    r.line = line_no;
    r.column = col[15:0];
    r.count = match_total[15:0];
  endfunction

  // Returns 1 when the accepted word produces a result word.
  function automatic bit search_step(input logic [1:0] mode, input logic [7:0] b,
                                     input logic [15:0] doc, output lss_pkg::result_t r);
    int unsigned span;
    int unsigned start;
    bit matched;
    bit emitted;
    r = '0;
    emitted = 1'b0;
    if (mode == lss_pkg::MODE_END_SEARCH) begin
      r.kind = lss_pkg::KIND_DONE;
      r.count = match_total[15:0];
      clear_search();
      return 1'b1;
    end
    if (mode == lss_pkg::MODE_END_DOC) begin
      clear_line();
      return 1'b0;
    end
    if (mode != lss_pkg::MODE_BYTE || halted) return 1'b0;
    if (b == lss_pkg::CHAR_LF) begin
      cr_match_held = 1'b0;
      if (line_no < LINE_SAT) line_no++;
      col_no = 0;
      recent_fill = 0;
      skip_count = 0;
      return 1'b0;
    end
    // A match held on a CR counts now, since this byte does not end the line.
    if (cr_match_held) begin
      cr_match_held = 1'b0;
      tally_match(r, held_doc, held_col);
      emitted = 1'b1;
      if (halted) return 1'b1;
    end
    if (col_no < COL_SAT) col_no++;
    for (int i = 31; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = b;
    if (recent_fill < 32) recent_fill++;
    span = needle_span();
    matched = 1'b0;
    if (skip_count > 0) begin
      skip_count--;
    end else if (recent_fill >= span) begin
      matched = 1'b1;
      for (int i = 0; i < span; i++) begin
        if (fold_case(recent_bytes[i]) != fold_case(cfg_needle[8*(span-1-i) +: 8])) begin
          matched = 1'b0;
        end
      end
    end
    if (!matched) return emitted;
    skip_count = span - 1;
    start = (col_no >= COL_SAT || col_no < span) ? COL_SAT : col_no - span + 1;
    if (b == lss_pkg::CHAR_CR) begin
      cr_match_held = 1'b1;
      held_col = start;
      held_doc = doc;
    end else if (!emitted) begin
      tally_match(r, doc, start);
      emitted = 1'b1;
    end
    return emitted;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, and the comparison of every word taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_stall_left > 0) begin
      m_tready <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
      m_tready <= 1'b0;
      sink_stall_left <= $urandom_range(0, 11);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : take_result
    lss_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result word, kind", m_tuser, 0);
      end else begin
        want = awaited_results.pop_front();
        case (want.kind)
          lss_pkg::KIND_HIT:   hits_seen++;
          lss_pkg::KIND_TRUNC: truncs_seen++;
          default:             dones_seen++;
        endcase
        if (m_tuser !== want.kind)          report_mismatch("kind", m_tuser, want.kind);
        if (m_tdata[15:0] !== want.doc)     report_mismatch("hit_doc", m_tdata[15:0], want.doc);
        if (m_tdata[47:16] !== want.line)   report_mismatch("hit_line", m_tdata[47:16], want.line);
        if (m_tdata[63:48] !== want.column) begin
          report_mismatch("hit_column", m_tdata[63:48], want.column);
        end
        if (m_tdata[79:64] !== want.count) begin
          report_mismatch("hit_count", m_tdata[79:64], want.count);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Offers one word, possibly after an idle burst, and steps the model once
  // the block has taken it. Always called right after a rising edge.
  task automatic send_word(input logic [1:0] mode, input logic [7:0] b,
                           input logic [15:0] doc);
    lss_pkg::result_t r;
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {doc, b};
    s_tuser <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    if (search_step(mode, b, doc, r)) awaited_results.insert(awaited_results.size(), r);
  endtask

  task automatic send_text(input string s, input logic [15:0] doc);
    for (int i = 0; i < s.len(); i++) send_word(lss_pkg::MODE_BYTE, s[i], doc);
  endtask

  task automatic end_doc();
    send_word(lss_pkg::MODE_END_DOC, 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)));
  endtask

  task automatic end_search();
    send_word(lss_pkg::MODE_END_SEARCH, 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)));
  endtask

  // Stops offering words, waits until every awaited result has arrived, and then
  // waits on for a word that is still inside the block.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all seven registers in a row; only called while the block is idle.
  task automatic program_search(input logic [255:0] needle, input logic [5:0] len,
                                input logic exact, input logic [15:0] limit);
    logic [lss_pkg::CFG_INDEX_BITS-1:0] idx [7];
    logic [63:0] val [7];
    idx = '{lss_pkg::REG_NEEDLE_LOW, lss_pkg::REG_NEEDLE_SECOND, lss_pkg::REG_NEEDLE_THIRD,
            lss_pkg::REG_NEEDLE_HIGH, lss_pkg::REG_NEEDLE_LENGTH,
            lss_pkg::REG_CASE_SENSITIVE, lss_pkg::REG_MAX_RESULTS};
    val = '{needle[63:0], needle[127:64], needle[191:128], needle[255:192],
            {58'd0, len}, {63'd0, exact}, {48'd0, limit}};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_needle = needle;
    cfg_len = len;
    cfg_exact = exact;
    cfg_limit = limit;
  endtask

  function automatic logic [255:0] needle_of(input string s);
    logic [255:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 32; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  // Swaps the case of a letter half of the time.
  function automatic logic [7:0] jitter_case(input logic [7:0] c);
    bit letter;
    letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    return (letter && $urandom_range(0, 1)) ? (c ^ 8'h20) : c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Plain hits over two lines and two documents, with the reset settings first.
  task automatic test_plain_hits();
    settle();
    send_text("q\nq", 16'h0000);        // reset needle is one zero byte: no hit
    end_doc();
    settle();
    program_search(needle_of("ab"), 6'd2, 1'b1, 16'd100);
    send_text("xabab\nab\r\n", 16'h0007);
    end_doc();
    send_text("aab", 16'hFFFF);
    send_word(MODE_UNUSED, "a", 16'hFFFF);
    send_text("b", 16'hFFFF);           // the ignored word leaves the window alone
    end_search();
  endtask

  // Caseless folds only A..Z, not the neighbors of the letter range; then exact case.
  task automatic test_caseless();
    settle();
    program_search(needle_of("z@"), 6'd2, 1'b0, 16'd100);
    send_text("Z@ z` [@ Z@", 16'h1234);
    end_doc();
    settle();
    program_search(needle_of("HeLLo"), 6'd5, 1'b1, 16'd100);
    send_text("hello HeLLo", 16'h4321);
    end_search();
  endtask

  // Leftmost non-overlapping matches: "aaa" in seven a's hits at 1 and 4.
  task automatic test_overlap();
    settle();
    program_search(needle_of("aaa"), 6'd3, 1'b1, 16'd100);
    send_text("aaaaaaa\naaaa", 16'h0042);
    end_search();
  endtask

  // A match ending on CR waits for the next byte: LF, end of document and
  // end of search drop it, any other byte releases it.
  task automatic test_cr_hold();
    settle();
    program_search(needle_of("z\r"), 6'd2, 1'b1, 16'd100);
    send_text("z\r\nz\rq", 16'h0101);
    send_text("z\r", 16'h0101);
    end_doc();
    send_text("z\r", 16'h0102);
    end_search();
    // A held match released by a byte that itself completes a new match,
    // with the needle changed while the match was held: the second is lost.
    settle();
    program_search(needle_of("\r"), 6'd1, 1'b1, 16'd100);
    send_text("a\r", 16'h0103);
    settle();
    program_search(needle_of("q"), 6'd1, 1'b1, 16'd100);
    send_text("qq", 16'h0103);
    end_search();
  endtask

  // Hit limit: truncated stop, ignored bytes, then done with the count.
  task automatic test_truncation();
    settle();
    program_search(needle_of("a"), 6'd1, 1'b1, 16'd2);
    send_text("aaaa", 16'h0200);
    end_doc();
    send_text("a", 16'h0201);
    end_search();
    settle();
    program_search(needle_of("a"), 6'd1, 1'b1, 16'd0);   // first match truncates
    send_text("ba", 16'h0202);
    end_search();
    settle();
    program_search(needle_of("a\r"), 6'd2, 1'b1, 16'd0);  // truncation on release
    send_text("a\rb", 16'h0203);
    end_search();
  endtask

  // Full-length needle, clamped oversize length, length zero, extreme bytes.
  task automatic test_needle_extremes();
    logic [255:0] wide;
    for (int i = 0; i < 32; i++) begin
      wide[8*i +: 8] = (i == 0) ? 8'h00 : (i == 31) ? 8'hFF : 8'(8'h80 + i);
    end
    settle();
    program_search(wide, 6'd32, 1'b0, 16'hFFFF);
    send_word(lss_pkg::MODE_BYTE, 8'h41, 16'hFFFF);
    for (int i = 0; i < 32; i++) send_word(lss_pkg::MODE_BYTE, wide[8*i +: 8], 16'hFFFF);
    end_doc();
    settle();
    program_search(wide, 6'd63, 1'b1, 16'hFFFF);          // clamps to 32
    for (int i = 0; i < 32; i++) send_word(lss_pkg::MODE_BYTE, wide[8*i +: 8], 16'h0000);
    end_doc();
    settle();
    program_search(wide, 6'd0, 1'b1, 16'hFFFF);           // acts as length one
    send_word(lss_pkg::MODE_BYTE, 8'hFF, 16'h0000);
    send_word(lss_pkg::MODE_BYTE, 8'h00, 16'h0000);
    end_search();
  endtask

  // One long line: the column keeps counting across many bytes, and a match
  // that ends on the last byte of the line still reports its start column.
  task automatic test_long_line();
    logic [7:0] c;
    settle();
    sender_idle_pct = 0;
    sink_idle_pct = 0;
    program_search(needle_of("ab"), 6'd2, 1'b1, 16'hFFFF);
    for (int n = 1; n <= 140; n++) begin
      case (n)
        1, 97, 139: c = "a";
        2, 98, 140: c = "b";
        default:    c = "x";
      endcase
      send_word(lss_pkg::MODE_BYTE, c, 16'h0777);
    end
    send_text("\nab", 16'h0777);
    end_search();
  endtask

  // Random documents of short lines built mostly from needle bytes, with
  // needle copies, stray bytes, CR LF endings and ignored words mixed in.
  task automatic test_random_documents();
    logic [255:0] needle;
    logic [5:0]   len;
    logic [15:0]  limit;
    logic [15:0]  doc;
    logic         exact;
    int unsigned  span;
    int budget, lines, count, pick;
    for (int phase = 0; phase < 7; phase++) begin
      settle();
      if (phase == 6) begin
        sender_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        sender_idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 12 : 35;
        sink_idle_pct = (phase % 2 == 0) ? 30 : 10;
      end
      for (int i = 0; i < 32; i++) begin
        pick = $urandom_range(0, 9);
        needle[8*i +: 8] = (pick < 3) ? "a" : (pick < 5) ? "B" : (pick < 7) ? "b" :
                           (pick < 8) ? lss_pkg::CHAR_CR : 8'($urandom_range(0, 255));
      end
      case (phase)
        1:       len = 6'd32;
        2:       len = 6'd0;
        3:       len = 6'd63;
        default: len = 6'($urandom_range(1, 4));
      endcase
      case (phase)
        1, 5:    limit = 16'hFFFF;
        2:       limit = 16'd0;
        default: limit = 16'($urandom_range(1, 8));
      endcase
      exact = 1'($urandom_range(0, 1));
      program_search(needle, len, exact, limit);
      span = needle_span();
      budget = words_sent + 60;
      while (words_sent < budget) begin
        doc = 16'($urandom_range(0, 65535));
        lines = $urandom_range(1, 4);
        for (int l = 0; l < lines; l++) begin
          count = $urandom_range(0, 12);
          for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
              for (int j = 0; j < span; j++) begin
                send_word(lss_pkg::MODE_BYTE, jitter_case(needle[8*j +: 8]), doc);
              end
            end else if (pick < 85) begin
              send_word(lss_pkg::MODE_BYTE,
                        jitter_case(needle[8*$urandom_range(0, span-1) +: 8]), doc);
            end else if (pick < 97) begin
              send_word(lss_pkg::MODE_BYTE, 8'($urandom_range(0, 255)), doc);
            end else begin
              send_word(MODE_UNUSED, 8'($urandom_range(0, 255)), doc);
            end
          end
          if ($urandom_range(0, 99) < 30) send_word(lss_pkg::MODE_BYTE, lss_pkg::CHAR_CR, doc);
          if (l < lines - 1 || $urandom_range(0, 1)) begin
            send_word(lss_pkg::MODE_BYTE, lss_pkg::CHAR_LF, doc);
          end
        end
        if ($urandom_range(0, 9) != 0) end_doc();
        // The sender holds off mid-phase until the block has caught up.
        if (phase == 3 && words_sent < budget - 30) settle();
      end
      end_search();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    words_sent = 0;
    mismatches = 0;
    hits_seen = 0;
    truncs_seen = 0;
    dones_seen = 0;
    cfg_needle = '0;
    cfg_len = 6'd1;
    cfg_exact = 1'b1;
    cfg_limit = 16'd100;
    clear_search();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 20;
    sink_idle_pct = 20;
    test_plain_hits();
    test_caseless();
    test_overlap();
    test_cr_hold();
    test_truncation();
    test_needle_extremes();
    test_long_line();
    test_random_documents();

    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d words over directed cases, a long line and random documents.",
             words_sent);
    $display("Checked %0d hits, %0d truncated stops and %0d search-done words.",
             hits_seen, truncs_seen, dones_seen);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run under the longest stalls.
  initial begin
    #(2_000_000);
    $display("Timed out with %0d results still awaited.", awaited_results.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lss_pkg.sv
hw/rtl/lss_cell.sv
hw/rtl/lss_out_queue.sv
hw/rtl/line_substring_search_top.sv
tb/tb_top.sv
